/* rtl/inversion_diameter_check_assert.svh */
// Assertion macros for the inversion diameter check.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef INVERSION_DIAMETER_CHECK_ASSERT_SVH
`define INVERSION_DIAMETER_CHECK_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked outside reset only.
`define IDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every edge, reset included.
`define IDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IDC_ASSERT(label, prop, msg)
`define IDC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* rtl/idc_pkg.sv */
// Shared constants of the inversion diameter check.
// No dependencies.
`timescale 1ns / 1ps

package idc_pkg;

  localparam int unsigned MarkW = 4;

  typedef logic [MarkW-1:0] mark_t;

  // Bit positions in a mark word.
  localparam int unsigned BitReached = 0;
  localparam int unsigned BitFront   = 1;
  localparam int unsigned BitNext    = 2;
  localparam int unsigned BitSeen    = 3;

  localparam mark_t MarkClear        = 4'b0000;
  localparam mark_t MarkReached      = 4'b0001;
  localparam mark_t MarkReachedFront = 4'b0011;
  localparam mark_t MarkReachedNext  = 4'b0101;
  localparam mark_t MarkSeen         = 4'b1000;

  localparam int unsigned RoundW    = 4;
  localparam int unsigned CountW    = 4;
  localparam int unsigned AdjW      = 28;
  localparam int unsigned FirstW    = 16;
  localparam int unsigned DistinctW = 9;
  localparam int unsigned EdgeCntW  = 5;

endpackage

/* rtl/idc_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module idc_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/inversion_diameter_check.sv */
// Inversion diameter check: top level with sequencer and shared mark memory.
// Depends on idc_pkg, idc_ram and inversion_diameter_check_assert.svh.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | vertex_count_i, adjacency_bits_i
//   out     | output    | out_valid_o/out_stall_i | within_diameter_o, first_unreached_o,
//           |           |                         | distinct_inversions_o, edges_exceed_limit_o
//   cfg     | input     | cfg_wr_en_i             | cfg_wr_data_i (max_distance)
//
// One graph at a time; in_stall_o is high from transfer until the result is loaded.
// Steps: the transfer, a pair scan over every vertex pair, a clear of the 2^m mark entries, a walk
// over the 2^n subsets, a collect pass, the seed, then per round a frontier scan visiting each listed
// vector per frontier label and an update pass, a final scan and the load; each mark read has a read
// state before its check. Over-limit graphs finish after the pair scan; marks are cleared per graph.
// A stalled result holds; the next graph waits only if its result would overwrite it.
`timescale 1ns / 1ps
`include "inversion_diameter_check_assert.svh"

module inversion_diameter_check #(
  parameter int unsigned MAX_VERTICES = 8,
  parameter int unsigned MAX_EDGES    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [idc_pkg::CountW-1:0]          vertex_count_i,
  input  logic [idc_pkg::AdjW-1:0]            adjacency_bits_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                within_diameter_o,
  output logic [idc_pkg::FirstW-1:0]          first_unreached_o,
  output logic [idc_pkg::DistinctW-1:0]       distinct_inversions_o,
  output logic                                edges_exceed_limit_o,
  input  logic                                cfg_wr_en_i,
  input  logic [idc_pkg::RoundW-1:0]          cfg_wr_data_i
);

  localparam int unsigned LW  = MAX_EDGES;
  localparam int unsigned LabelDepth = 1 << MAX_EDGES;
  localparam int unsigned VW  = MAX_VERTICES;
  localparam int unsigned ListDepth = 1 << MAX_VERTICES;
  localparam int unsigned VIW = $clog2(MAX_VERTICES);
  localparam int unsigned EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned PW  = idc_pkg::EdgeCntW;

  typedef enum logic [4:0] {
    IDLE, SCAN, CLEAR, SUBSET, COL_RD, COL_CHK, SEED, FR_RD, FR_CHK,
    V_RD, M_RD, M_CHK, UP_RD, UP_CHK, FIN_RD, FIN_CHK, FINISH
  } state_e;

  state_e state_q;

  logic [idc_pkg::RoundW-1:0]   max_dist_q;
  logic [idc_pkg::RoundW-1:0]   round_q;
  logic [idc_pkg::CountW-1:0]   n_q;
  logic [idc_pkg::AdjW-1:0]     adj_q;
  logic [VIW-1:0]               u_q, v_q;
  logic [PW-1:0]                p_q;
  logic [idc_pkg::EdgeCntW-1:0] m_q;
  logic [VIW-1:0]               eu_q [MAX_EDGES];
  logic [VIW-1:0]               ev_q [MAX_EDGES];
  logic [LW-1:0]                last_q;
  logic [LW-1:0]                c_q;
  logic [LW-1:0]                d_q;
  logic [VW-1:0]                s_q;
  logic [VW:0]                  cnt_q;
  logic [VW-1:0]                i_q;
  logic                         exceed_q;
  logic                         all_q;
  logic [LW-1:0]                first_q;

  logic                         out_valid_q;
  logic                         within_q;
  logic [idc_pkg::FirstW-1:0]   first_out_q;
  logic [idc_pkg::DistinctW-1:0] distinct_q;
  logic                         exceed_out_q;

  logic            mk_we;
  logic [LW-1:0]   mk_waddr, mk_raddr;
  idc_pkg::mark_t  mk_wdata, mk_rdata;
  logic            vl_we;
  logic [LW-1:0]   vl_rdata;

  logic [VW-1:0]        last_s;
  logic [LW-1:0]        last_m;
  logic [MAX_EDGES-1:0] edge_hit;
  logic [LW-1:0]        vec;
  logic [LW-1:0]        d_next;
  logic                 pair_live;
  logic [idc_pkg::CountW-1:0] n_sat;

  // Subset mask, label mask and subset inversion vector.
  always_comb begin
    for (int j = 0; j < VW; j++) begin
      last_s[j] = (j < int'(n_q));
    end
    for (int j = 0; j < LW; j++) begin
      last_m[j] = (j < int'(m_q));
    end
    for (int e = 0; e < MAX_EDGES; e++) begin
      edge_hit[e] = (e < int'(m_q)) && s_q[eu_q[e]] && s_q[ev_q[e]];
    end
    for (int j = 0; j < LW; j++) begin
      vec[j] = (j < int'(m_q)) ? edge_hit[EIW'(int'(m_q) - 1 - j)] : 1'b0;
    end
  end

  assign d_next    = (vl_rdata ^ c_q) & last_q;
  assign pair_live = (int'(v_q) < int'(n_q));
  assign n_sat     = (int'(vertex_count_i) > MAX_VERTICES) ?
                     idc_pkg::CountW'(MAX_VERTICES) : vertex_count_i;

  always_comb begin
    mk_we    = 1'b0;
    mk_waddr = c_q;
    mk_wdata = idc_pkg::MarkClear;
    mk_raddr = c_q;
    vl_we    = 1'b0;
    case (state_q)
      CLEAR: begin
        mk_we = 1'b1;
      end
      SUBSET: begin
        mk_we    = 1'b1;
        mk_waddr = vec;
        mk_wdata = idc_pkg::MarkSeen;
      end
      COL_CHK: begin
        vl_we = mk_rdata[idc_pkg::BitSeen];
      end
      SEED: begin
        mk_we    = 1'b1;
        mk_waddr = '0;
        mk_wdata = idc_pkg::MarkReachedFront;
      end
      M_RD: begin
        mk_raddr = d_next;
      end
      M_CHK: begin
        mk_we    = !mk_rdata[idc_pkg::BitReached];
        mk_waddr = d_q;
        mk_wdata = idc_pkg::MarkReachedNext;
      end
      UP_CHK: begin
        if (mk_rdata[idc_pkg::BitNext]) begin
          mk_we    = 1'b1;
          mk_wdata = idc_pkg::MarkReachedFront;
        end else if (mk_rdata[idc_pkg::BitFront]) begin
          mk_we    = 1'b1;
          mk_wdata = idc_pkg::MarkReached;
        end
      end
      default: begin
      end
    endcase
  end

  idc_ram #(
    .Width (idc_pkg::MarkW),
    .Depth (LabelDepth)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mk_we),
    .waddr_i (mk_waddr),
    .wdata_i (mk_wdata),
    .raddr_i (mk_raddr),
    .rdata_o (mk_rdata)
  );

  idc_ram #(
    .Width (LW),
    .Depth (ListDepth)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (vl_we),
    .waddr_i (cnt_q[VW-1:0]),
    .wdata_i (c_q),
    .raddr_i (i_q),
    .rdata_o (vl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      max_dist_q   <= idc_pkg::RoundW'(2);
      round_q      <= '0;
      n_q          <= '0;
      adj_q        <= '0;
      u_q          <= '0;
      v_q          <= '0;
      p_q          <= '0;
      m_q          <= '0;
      last_q       <= '0;
      c_q          <= '0;
      d_q          <= '0;
      s_q          <= '0;
      cnt_q        <= '0;
      i_q          <= '0;
      exceed_q     <= 1'b0;
      all_q        <= 1'b0;
      first_q      <= '0;
      out_valid_q  <= 1'b0;
      within_q     <= 1'b0;
      first_out_q  <= '0;
      distinct_q   <= '0;
      exceed_out_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        max_dist_q <= cfg_wr_data_i;
      end
      if (out_valid_q && !out_stall_i && (state_q != FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (in_valid_i) begin
            n_q     <= n_sat;
            adj_q   <= adjacency_bits_i;
            u_q     <= '0;
            v_q     <= VIW'(1);
            p_q     <= '0;
            m_q     <= '0;
            state_q <= SCAN;
          end
        end
        SCAN: begin
          if (pair_live) begin
            if (adj_q[p_q]) begin
              if (int'(m_q) < MAX_EDGES) begin
                eu_q[m_q[EIW-1:0]] <= u_q;
                ev_q[m_q[EIW-1:0]] <= v_q;
              end
              m_q <= m_q + 1'b1;
            end
            p_q <= p_q + 1'b1;
          end
          if (int'(v_q) == MAX_VERTICES - 1) begin
            if (int'(u_q) == MAX_VERTICES - 2) begin
              c_q <= '0;
              if (int'(m_q) + int'(pair_live && adj_q[p_q]) > MAX_EDGES) begin
                exceed_q <= 1'b1;
                state_q  <= FINISH;
              end else begin
                exceed_q <= 1'b0;
                state_q  <= CLEAR;
              end
            end else begin
              u_q <= u_q + 1'b1;
              v_q <= u_q + VIW'(2);
            end
          end else begin
            v_q <= v_q + 1'b1;
          end
        end
        CLEAR: begin
          last_q <= last_m;
          if (c_q == last_m) begin
            s_q     <= '0;
            state_q <= SUBSET;
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        SUBSET: begin
          if (s_q == last_s) begin
            c_q     <= '0;
            cnt_q   <= '0;
            state_q <= COL_RD;
          end else begin
            s_q <= s_q + 1'b1;
          end
        end
        COL_RD: begin
          state_q <= COL_CHK;
        end
        COL_CHK: begin
          if (mk_rdata[idc_pkg::BitSeen]) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (c_q == last_q) begin
            state_q <= SEED;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= COL_RD;
          end
        end
        SEED: begin
          c_q     <= '0;
          round_q <= '0;
          state_q <= (max_dist_q == '0) ? FIN_RD : FR_RD;
        end
        FR_RD: begin
          state_q <= FR_CHK;
        end
        FR_CHK: begin
          if (mk_rdata[idc_pkg::BitFront]) begin
            i_q     <= '0;
            state_q <= V_RD;
          end else if (c_q == last_q) begin
            c_q     <= '0;
            state_q <= UP_RD;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= FR_RD;
          end
        end
        V_RD: begin
          state_q <= M_RD;
        end
        M_RD: begin
          d_q     <= d_next;
          state_q <= M_CHK;
        end
        M_CHK: begin
          if ({1'b0, i_q} != cnt_q - 1'b1) begin
            i_q     <= i_q + 1'b1;
            state_q <= V_RD;
          end else if (c_q == last_q) begin
            c_q     <= '0;
            state_q <= UP_RD;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= FR_RD;
          end
        end
        UP_RD: begin
          state_q <= UP_CHK;
        end
        UP_CHK: begin
          if (c_q == last_q) begin
            c_q     <= '0;
            round_q <= round_q + 1'b1;
            state_q <= (round_q + 1'b1 == max_dist_q) ? FIN_RD : FR_RD;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= UP_RD;
          end
        end
        FIN_RD: begin
          state_q <= FIN_CHK;
        end
        FIN_CHK: begin
          if (!mk_rdata[idc_pkg::BitReached]) begin
            all_q   <= 1'b0;
            first_q <= c_q;
            state_q <= FINISH;
          end else if (c_q == last_q) begin
            all_q   <= 1'b1;
            first_q <= '0;
            state_q <= FINISH;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= FIN_RD;
          end
        end
        FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            exceed_out_q <= exceed_q;
            within_q     <= !exceed_q && all_q;
            first_out_q  <= exceed_q ? '0 : idc_pkg::FirstW'(first_q);
            distinct_q   <= exceed_q ? '0 : idc_pkg::DistinctW'(cnt_q);
            state_q      <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign in_stall_o            = (state_q != IDLE);
  assign out_valid_o           = out_valid_q;
  assign within_diameter_o     = within_q;
  assign first_unreached_o     = first_out_q;
  assign distinct_inversions_o = distinct_q;
  assign edges_exceed_limit_o  = exceed_out_q;

  `IDC_ASSERT(a_accept_starts_scan, (in_valid_i && !in_stall_o) |=> (state_q == SCAN), "transfer did not start pair scan")
  `IDC_ASSERT(a_result_from_finish, $rose(out_valid_o) |-> $past(state_q == FINISH), "result raised outside finish")
  `IDC_ASSERT_ALWAYS(a_exceed_zeroes, (out_valid_o && edges_exceed_limit_o) |-> (!within_diameter_o && distinct_inversions_o == '0), "over-limit result carries data")
  `IDC_ASSERT(a_empty_subset_counted, (out_valid_o && !edges_exceed_limit_o) |-> (distinct_inversions_o != '0), "zero vector missing from count")

endmodule
